@@ src/imlt_pkg.sv @@
// Package for the IRC message line tokenizer.
// Holds the size limits, byte codes, field codes and parser phase type.
// No dependencies.
package imlt_pkg;

  // Size limits of the tokenizer.
  localparam int MAX_PARAMS  = 15;
  localparam int PARAM_LEN   = 512;
  localparam int PREFIX_LEN  = 128;
  localparam int COMMAND_LEN = 32;

  // Widths of the payload fields.
  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int PIDX_W  = 4;
  localparam int POS_W   = 9;
  // One bit wider than an offset, so a limit of 512 fits.
  localparam int LEN_W   = POS_W + 1;

  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_LOW_A = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LOW_Z = 8'h7A;
  localparam logic [BYTE_W-1:0] CASE_GAP = 8'h20;

  localparam logic ITEM_CHAR    = 1'b0;
  localparam logic ITEM_SUMMARY = 1'b1;

  localparam logic [KIND_W-1:0] FK_PREFIX  = 2'd0;
  localparam logic [KIND_W-1:0] FK_COMMAND = 2'd1;
  localparam logic [KIND_W-1:0] FK_PARAM   = 2'd2;

  localparam logic [LEN_W-1:0] PARAM_LIM   = LEN_W'(PARAM_LEN);
  localparam logic [LEN_W-1:0] PREFIX_LIM  = LEN_W'(PREFIX_LEN);
  localparam logic [LEN_W-1:0] COMMAND_LIM = LEN_W'(COMMAND_LEN);
  localparam logic [PIDX_W-1:0] PARAM_MAX  = PIDX_W'(MAX_PARAMS);

  typedef enum logic [7:0] {
    PH_LEAD         = 8'b0000_0001,
    PH_PREFIX       = 8'b0000_0010,
    PH_AFTER_PREFIX = 8'b0000_0100,
    PH_COMMAND      = 8'b0000_1000,
    PH_GAP          = 8'b0001_0000,
    PH_PARAM        = 8'b0010_0000,
    PH_TRAIL        = 8'b0100_0000,
    PH_DROP         = 8'b1000_0000
  } phase_t;

endpackage

@@ src/imlt_if.sv @@
// Valid/ready channel interfaces for the IRC message line tokenizer.
// Depends on imlt_pkg for the field widths.
interface imlt_in_if;
  logic                         valid;
  logic                         ready;
  logic [imlt_pkg::BYTE_W-1:0]  byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface imlt_out_if;
  logic                         valid;
  logic                         ready;
  logic                         item_kind;
  logic [imlt_pkg::KIND_W-1:0]  field_kind;
  logic [imlt_pkg::PIDX_W-1:0]  param_index;
  logic [imlt_pkg::POS_W-1:0]   char_pos;
  logic [imlt_pkg::BYTE_W-1:0]  char_out;
  logic                         line_valid;
  logic [imlt_pkg::PIDX_W-1:0]  param_total;

  modport source (output valid, output item_kind, output field_kind, output param_index,
                  output char_pos, output char_out, output line_valid,
                  output param_total, input ready);
  modport sink   (input valid, input item_kind, input field_kind, input param_index,
                  input char_pos, input char_out, input line_valid,
                  input param_total, output ready);
endinterface

@@ src/irc_message_line_tokenizer.sv @@
// The tokenizer takes one IRC line a byte per cycle and a zero byte ends it. Each byte is
// parsed in the cycle it is accepted and its result item, if any, sits in the output
// register from the next cycle on; a new byte is accepted in every cycle in which that
// register is empty or being read, so the sustained rate is one byte per cycle. Kept
// characters come out tagged with field, parameter index and offset; the zero byte
// gives a summary item, and a summary with line_valid low means the line must be
// discarded.
// Depends on imlt_pkg and the channel interfaces in imlt_if.sv.
module irc_message_line_tokenizer (
  input  logic                clk,
  input  logic                rst_n,
  imlt_in_if.sink             in_ch,
  imlt_out_if.source          out_ch
);
  import imlt_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [POS_W-1:0]    offset_r, offset_nxt;
  logic [PIDX_W-1:0]   params_r, params_nxt;
  logic                cmd_r, cmd_nxt;

  logic                out_valid_r;
  logic                out_kind_r;
  logic [KIND_W-1:0]   out_field_r;
  logic [PIDX_W-1:0]   out_pidx_r;
  logic [POS_W-1:0]    out_pos_r;
  logic [BYTE_W-1:0]   out_char_r;
  logic                out_lvalid_r;
  logic [PIDX_W-1:0]   out_ptotal_r;

  logic                accept;
  logic [BYTE_W-1:0]   b;
  logic [BYTE_W-1:0]   ch_upper;
  logic                field_start;
  logic [POS_W-1:0]    base_off;
  logic                put;
  logic [KIND_W-1:0]   put_kind;
  logic [LEN_W-1:0]    put_lim;
  logic [BYTE_W-1:0]   put_char;
  logic                fits;
  logic                emit;
  logic                summary;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.byte_in;
  assign ch_upper    = (b >= CH_LOW_A && b <= CH_LOW_Z) ? (b - CASE_GAP) : b;

  always_comb begin
    phase_nxt   = phase_r;
    params_nxt  = params_r;
    cmd_nxt     = cmd_r;
    field_start = 1'b0;
    put         = 1'b0;
    put_kind    = FK_PARAM;
    put_lim     = PARAM_LIM;
    put_char    = b;
    summary     = 1'b0;
    if (b == CH_NUL) begin
      summary = 1'b1;
    end else begin
      unique case (phase_r)
        PH_LEAD: begin
          if (b != CH_SPACE) begin
            field_start = 1'b1;
            if (b == CH_COLON) begin
              phase_nxt = PH_PREFIX;
            end else begin
              phase_nxt = PH_COMMAND;
              put       = 1'b1;
            end
          end
        end
        PH_PREFIX: begin
          if (b == CH_SPACE) begin
            phase_nxt = PH_AFTER_PREFIX;
          end else begin
            put = 1'b1;
          end
          put_kind = FK_PREFIX;
          put_lim  = PREFIX_LIM;
        end
        PH_AFTER_PREFIX: begin
          if (b != CH_SPACE) begin
            field_start = 1'b1;
            phase_nxt   = PH_COMMAND;
            put         = 1'b1;
          end
        end
        PH_COMMAND: begin
          if (b == CH_SPACE) begin
            phase_nxt = PH_GAP;
          end else begin
            put = 1'b1;
          end
        end
        PH_GAP: begin
          if (b != CH_SPACE) begin
            if (params_r >= PARAM_MAX) begin
              phase_nxt = PH_DROP;
            end else begin
              params_nxt  = params_r + 1'b1;
              field_start = 1'b1;
              if (b == CH_COLON) begin
                phase_nxt = PH_TRAIL;
              end else begin
                phase_nxt = PH_PARAM;
                put       = 1'b1;
              end
            end
          end
        end
        PH_PARAM: begin
          if (b == CH_SPACE) begin
            phase_nxt = PH_GAP;
          end else begin
            put = 1'b1;
          end
        end
        PH_TRAIL: begin
          put = 1'b1;
        end
        PH_DROP: begin
        end
        default: begin
        end
      endcase
      // Command characters are folded to upper case and mark the line as valid.
      if (phase_nxt == PH_COMMAND && put) begin
        put_kind = FK_COMMAND;
        put_lim  = COMMAND_LIM;
        put_char = ch_upper;
        cmd_nxt  = 1'b1;
      end
    end
  end

  assign base_off = field_start ? '0 : offset_r;
  assign fits     = ({1'b0, base_off} + LEN_W'(1)) < put_lim;
  assign emit     = put && fits;

  always_comb begin
    offset_nxt = emit ? (base_off + 1'b1) : base_off;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEAD;
      offset_r    <= '0;
      params_r    <= '0;
      cmd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        if (summary) begin
          phase_r  <= PH_LEAD;
          offset_r <= '0;
          params_r <= '0;
          cmd_r    <= 1'b0;
        end else begin
          phase_r  <= phase_nxt;
          offset_r <= offset_nxt;
          params_r <= params_nxt;
          cmd_r    <= cmd_nxt;
        end
        out_valid_r <= summary || emit;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (summary) begin
        out_kind_r   <= ITEM_SUMMARY;
        out_field_r  <= FK_PREFIX;
        out_pidx_r   <= '0;
        out_pos_r    <= '0;
        out_char_r   <= CH_NUL;
        out_lvalid_r <= cmd_r;
        out_ptotal_r <= cmd_r ? params_r : '0;
      end else begin
        out_kind_r   <= ITEM_CHAR;
        out_field_r  <= put_kind;
        out_pidx_r   <= (put_kind == FK_PARAM) ? (params_nxt - 1'b1) : '0;
        out_pos_r    <= base_off;
        out_char_r   <= put_char;
        out_lvalid_r <= 1'b0;
        out_ptotal_r <= '0;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.item_kind   = out_kind_r;
  assign out_ch.field_kind  = out_field_r;
  assign out_ch.param_index = out_pidx_r;
  assign out_ch.char_pos    = out_pos_r;
  assign out_ch.char_out    = out_char_r;
  assign out_ch.line_valid  = out_lvalid_r;
  assign out_ch.param_total = out_ptotal_r;

endmodule

@@ dv/tb_irc_message_line_tokenizer.sv @@
// Testbench for irc_message_line_tokenizer: drives IRC line bytes with random gaps and
// stalls, predicts every character and summary item in SystemVerilog, and checks them.
// Depends on imlt_pkg, the channel interfaces in imlt_if.sv and the tokenizer RTL.
`timescale 1ns / 1ps

module tb_irc_message_line_tokenizer;
  import imlt_pkg::*;

  typedef struct packed {
    logic                item_kind;
    logic [KIND_W-1:0]   field_kind;
    logic [PIDX_W-1:0]   param_index;
    logic [POS_W-1:0]    char_pos;
    logic [BYTE_W-1:0]   char_out;
    logic                line_valid;
    logic [PIDX_W-1:0]   param_total;
  } token_t;

  logic clk = 1'b0;
  logic rst_n;

  imlt_in_if  in_ch();
  imlt_out_if out_ch();

  irc_message_line_tokenizer u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Line parser state mirrored from the block.
  phase_t tok_phase    = PH_LEAD;
  int     tok_offset   = 0;
  int     tok_params   = 0;
  logic   tok_cmd_seen = 1'b0;

  token_t pending_tokens[$];
  token_t got_tok;
  token_t want_tok;

  int  n_errors   = 0;
  int  n_sent     = 0;
  int  n_checked  = 0;
  int  n_lines    = 0;
  bit  src_steady = 1'b0;
  bit  sink_steady = 1'b0;
  int  stall_req  = 0;

  function automatic bit keep_char(input logic [KIND_W-1:0] kind, input int idx,
                                   input int limit, input logic [7:0] ch,
                                   output token_t t);
    t = '0;
    if (tok_offset + 1 >= limit) return 1'b0;
    t.item_kind   = ITEM_CHAR;
    t.field_kind  = kind;
    t.param_index = idx[PIDX_W-1:0];
    t.char_pos    = tok_offset[POS_W-1:0];
    t.char_out    = ch;
    tok_offset++;
    return 1'b1;
  endfunction

  function automatic bit command_byte(input logic [7:0] b, output token_t t);
    logic [7:0] c;
    c = b;
    if (c >= CH_LOW_A && c <= CH_LOW_Z) c = c - CASE_GAP;
    tok_cmd_seen = 1'b1;
    return keep_char(FK_COMMAND, 0, COMMAND_LEN, c, t);
  endfunction

  // Advances the parser by one byte; returns 1 when the byte yields a result item.
  function automatic bit tokenize_byte(input logic [7:0] b, output token_t t);
    t = '0;
    if (b == CH_NUL) begin
      t.item_kind   = ITEM_SUMMARY;
      t.line_valid  = tok_cmd_seen;
      t.param_total = tok_cmd_seen ? tok_params[PIDX_W-1:0] : '0;
      tok_phase    = PH_LEAD;
      tok_offset   = 0;
      tok_params   = 0;
      tok_cmd_seen = 1'b0;
      return 1'b1;
    end
    case (tok_phase)
      PH_LEAD, PH_AFTER_PREFIX: begin
        if (b == CH_SPACE) return 1'b0;
        tok_offset = 0;
        if (tok_phase == PH_LEAD && b == CH_COLON) begin
          tok_phase = PH_PREFIX;
          return 1'b0;
        end
        tok_phase = PH_COMMAND;
        return command_byte(b, t);
      end
      PH_PREFIX: begin
        if (b == CH_SPACE) begin
          tok_phase = PH_AFTER_PREFIX;
          return 1'b0;
        end
        return keep_char(FK_PREFIX, 0, PREFIX_LEN, b, t);
      end
      PH_COMMAND: begin
        if (b == CH_SPACE) begin
          tok_phase = PH_GAP;
          return 1'b0;
        end
        return command_byte(b, t);
      end
      PH_GAP: begin
        if (b == CH_SPACE) return 1'b0;
        if (tok_params >= MAX_PARAMS) begin
          tok_phase = PH_DROP;
          return 1'b0;
        end
        tok_params++;
        tok_offset = 0;
        if (b == CH_COLON) begin
          tok_phase = PH_TRAIL;
          return 1'b0;
        end
        tok_phase = PH_PARAM;
        return keep_char(FK_PARAM, tok_params - 1, PARAM_LEN, b, t);
      end
      PH_PARAM: begin
        if (b == CH_SPACE) begin
          tok_phase = PH_GAP;
          return 1'b0;
        end
        return keep_char(FK_PARAM, tok_params - 1, PARAM_LEN, b, t);
      end
      PH_TRAIL: return keep_char(FK_PARAM, tok_params - 1, PARAM_LEN, b, t);
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (n_errors < 40)
      $display("%0t: %s: got %0d, want %0d (result %0d)", $time, what, got, want, n_checked);
    n_errors++;
  endtask

  task automatic compare_token(input token_t got, input token_t want);
    if (got.item_kind !== want.item_kind)
      report_mismatch("item_kind", got.item_kind, want.item_kind);
    if (got.field_kind !== want.field_kind)
      report_mismatch("field_kind", got.field_kind, want.field_kind);
    if (got.param_index !== want.param_index)
      report_mismatch("param_index", got.param_index, want.param_index);
    if (got.char_pos !== want.char_pos)
      report_mismatch("char_pos", got.char_pos, want.char_pos);
    if (got.char_out !== want.char_out)
      report_mismatch("char_out", got.char_out, want.char_out);
    if (got.line_valid !== want.line_valid)
      report_mismatch("line_valid", got.line_valid, want.line_valid);
    if (got.param_total !== want.param_total)
      report_mismatch("param_total", got.param_total, want.param_total);
  endtask

  // Predicts on every accepted byte and checks every accepted result item.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready && tokenize_byte(in_ch.byte_in, want_tok))
        pending_tokens.push_back(want_tok);
      if (out_ch.valid && out_ch.ready) begin
        got_tok = '{out_ch.item_kind, out_ch.field_kind, out_ch.param_index,
                    out_ch.char_pos, out_ch.char_out, out_ch.line_valid,
                    out_ch.param_total};
        if (pending_tokens.size() == 0) begin
          report_mismatch("result item with nothing pending", got_tok.char_out, 0);
        end else begin
          compare_token(got_tok, pending_tokens.pop_front());
        end
        if (got_tok.item_kind == ITEM_SUMMARY) n_lines++;
        n_checked++;
      end
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: random stalls, steady stretches, and a long hold when requested.
  initial begin
    int hold;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req > 0) begin
        hold = stall_req;
        stall_req = 0;
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end else if (sink_steady || $urandom_range(0, 99) < 65) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = src_steady ? 0 : idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.byte_in <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    n_sent++;
  endtask

  task automatic send_line(input logic [7:0] q[$]);
    foreach (q[i]) send_byte(q[i]);
    send_byte(CH_NUL);
  endtask

  function automatic logic [7:0] data_byte();
    logic [7:0] b;
    if ($urandom_range(0, 4) != 0) b = 8'($urandom_range(8'h21, 8'h7E));
    else b = 8'($urandom_range(1, 255));
    if (b == CH_SPACE) b = 8'h5F;
    return b;
  endfunction

  function automatic logic [7:0] noise_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return CH_SPACE;
    if (r < 35) return CH_COLON;
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic push_word(ref logic [7:0] q[$], input int n);
    repeat (n) q.push_back(data_byte());
  endtask

  task automatic push_spaces(ref logic [7:0] q[$], input int n);
    repeat (n) q.push_back(CH_SPACE);
  endtask

  task automatic push_text(ref logic [7:0] q[$], input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endtask

  task automatic send_text(input string s);
    logic [7:0] q[$];
    push_text(q, s);
    send_line(q);
  endtask

  // Short lines: prefix, case folding, colon inside the command, empty command,
  // empty trailing parameter and the byte extremes.
  task automatic test_directed();
    logic [7:0] q[$];
    send_text(" :Pz cm:d x :y z");
    send_text("");
    send_text(":p");
    send_text("A :");
    push_text(q, "`az{");
    q.push_back(8'hFF);
    q.push_back(CH_SPACE);
    q.push_back(8'h01);
    q.push_back(8'h80);
    send_line(q);
  endtask

  // Fields around their size limits, where the tail characters are dropped.
  task automatic test_long_fields();
    logic [7:0] q[$];
    q.push_back(CH_COLON);
    push_word(q, $urandom_range(PREFIX_LEN - 2, PREFIX_LEN + 2));
    push_spaces(q, 1);
    push_word(q, $urandom_range(COMMAND_LEN - 2, COMMAND_LEN + 2));
    send_line(q);
    q = {};
    push_text(q, "P ");
    push_word(q, $urandom_range(PARAM_LEN - 2, PARAM_LEN + 2));
    send_line(q);
    q = {};
    push_text(q, "P :");
    repeat ($urandom_range(PARAM_LEN - 1, PARAM_LEN + 2))
      q.push_back(($urandom_range(0, 3) == 0) ? CH_SPACE : data_byte());
    send_line(q);
  endtask

  // Parameter counts at and past the maximum, with and without a trailing one.
  task automatic test_param_limit();
    logic [7:0] q[$];
    push_text(q, "x");
    repeat (MAX_PARAMS + 2) begin
      push_spaces(q, 1);
      push_word(q, $urandom_range(1, 3));
    end
    send_line(q);
    for (int k = MAX_PARAMS - 1; k <= MAX_PARAMS; k++) begin
      q = {};
      push_text(q, "X");
      repeat (k) begin
        push_spaces(q, $urandom_range(1, 2));
        push_word(q, $urandom_range(1, 2));
      end
      push_text(q, " :tail end");
      send_line(q);
    end
  endtask

  // The receiver holds off while the sender keeps offering, so the input must stall.
  task automatic test_backpressure();
    logic [7:0] q[$];
    src_steady  = 1'b1;
    sink_steady = 1'b1;
    @(posedge clk);
    stall_req = 80;
    push_text(q, ":srv NOTICE #chan :held output while stalled");
    send_line(q);
    src_steady  = 1'b0;
    sink_steady = 1'b0;
  endtask

  // Mostly well-formed lines with random content; the rest is noise.
  // Runs until the whole run has sent about 1650 bytes.
  task automatic test_random_lines();
    logic [7:0] q[$];
    int n_par;
    int target;
    target = 1650;
    while (n_sent < target) begin
      src_steady  = ($urandom_range(0, 7) == 0);
      sink_steady = ($urandom_range(0, 7) == 0);
      q = {};
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(0, 20)) q.push_back(noise_byte());
      end else begin
        push_spaces(q, $urandom_range(0, 2));
        if ($urandom_range(0, 1)) begin
          q.push_back(CH_COLON);
          push_word(q, $urandom_range(0, 10));
          push_spaces(q, $urandom_range(1, 2));
        end
        // Now and then the command is left out entirely.
        if ($urandom_range(0, 19) != 0) begin
          push_word(q, $urandom_range(1, 8));
          n_par = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 5)
                                              : $urandom_range(MAX_PARAMS - 2, MAX_PARAMS + 2);
          repeat (n_par) begin
            push_spaces(q, $urandom_range(1, 3));
            push_word(q, $urandom_range(1, 8));
          end
          if ($urandom_range(0, 2) == 0) begin
            push_spaces(q, 1);
            q.push_back(CH_COLON);
            repeat ($urandom_range(0, 12))
              q.push_back(($urandom_range(0, 3) == 0) ? CH_SPACE : data_byte());
          end
        end
        push_spaces(q, $urandom_range(0, 1));
      end
      send_line(q);
    end
    src_steady  = 1'b0;
    sink_steady = 1'b0;
  endtask

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.byte_in = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_long_fields();
    test_param_limit();
    test_backpressure();
    test_random_lines();
    in_ch.valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d bytes; checked %0d result items across %0d line summaries.",
             n_sent, n_checked, n_lines);
    $display("Lines covered prefixes, long fields, parameter overflow and output stalls.");
    if (n_errors == 0) begin
      $display("irc_message_line_tokenizer: match");
    end else begin
      $display("irc_message_line_tokenizer: mismatch");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timed out with %0d result items still pending.", pending_tokens.size());
    $display("irc_message_line_tokenizer: mismatch");
    $finish;
  end

endmodule
